### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the stack calculator step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

    localparam int STACK_DEPTH  = 64;
    localparam int NUM_VARS     = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int NUM_ROUTINES = 256;

    localparam int SIZE_W      = $clog2(STACK_DEPTH + 1);
    // top two entries live in registers; the RAM holds the rest
    localparam int STK_MEM_DEPTH = STACK_DEPTH - 2;
    localparam int STK_ADDR_W  = $clog2(STK_MEM_DEPTH);
    localparam int VAR_IDX_W   = $clog2(NUM_VARS);
    localparam int ROUTINE_W   = $clog2(NUM_ROUTINES);

    typedef enum logic [3:0] {
        OP_PUSH   = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_MUL    = 4'd3,
        OP_READ   = 4'd4,
        OP_WRITE  = 4'd5,
        OP_JUMP   = 4'd6,
        OP_JUMPZ  = 4'd7,
        OP_ASSIGN = 4'd8
    } mode_t;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] constant;
        logic [3:0]         var_index;
        logic [7:0]         target_routine;
    } cmd_t;

    typedef struct packed {
        logic               jump_taken;
        logic [7:0]         routine;
        logic [15:0]        instr_index;
        logic signed [31:0] top_value;
        logic [6:0]         stack_count;
        logic [31:0]        time_now;
        logic               overflow_flag;
        logic signed [31:0] var_value;
    } res_t;

    typedef struct packed {
        logic                  en;
        logic [STK_ADDR_W-1:0] addr;
        logic [DATA_WIDTH-1:0] data;
    } stk_wr_t;

    typedef struct packed {
        logic                  en;
        logic [VAR_IDX_W-1:0]  idx;
        logic [DATA_WIDTH-1:0] data;
    } var_wr_t;

endpackage

`default_nettype wire

### rtl/scp_stack_ram.sv
// ----------------------------------------------------------------------------
// scp_stack_ram
// Stack spill RAM: one write port, one read port, registered read data with
// write-to-read bypass on an address match.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_stack_ram
    import scp_pkg::*;
(
    input  wire logic                  clk,
    input  wire stk_wr_t               wr,
    input  wire logic [STK_ADDR_W-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]      rd_data
);

    logic [DATA_WIDTH-1:0] mem [STK_MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data <= wr.data;
        end
        else
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/scp_var_bank.sv
// ----------------------------------------------------------------------------
// scp_var_bank
// Variable bank: NUM_VARS words cleared at reset, one write and one read.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_var_bank
    import scp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire var_wr_t              wr,
    input  wire logic [VAR_IDX_W-1:0] rd_idx,
    output logic [DATA_WIDTH-1:0]     rd_data
);

    logic [DATA_WIDTH-1:0] vars_reg [NUM_VARS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VARS; i++)
            begin
                vars_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            vars_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = vars_reg[rd_idx];

endmodule

`default_nettype wire

### rtl/stack_calculator_step_unit.sv
// ----------------------------------------------------------------------------
// stack_calculator_step_unit
// Stack calculator: executes one instruction per item.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns its result in the cycle after it is
// accepted, from an output register; a new item is taken whenever that
// register is empty or being emptied. The top two stack entries sit in
// registers and the deeper entries in a RAM whose registered read port always
// holds the third entry of the stack as it stands after the last item, so a
// pop never waits; a push writes the spilled entry to the same RAM address in
// the same cycle and is bypassed into the read register. The multiply sits
// between the top-of-stack registers and the state/output registers and sets
// the cycle time. No clearing pass after reset: the unit is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_calculator_step_unit
    import scp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    localparam logic [SIZE_W-1:0] SIZE_FULL = SIZE_W'(STACK_DEPTH);

    // control and state
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [31:0]           time_reg, time_next;
    logic [ROUTINE_W-1:0]  routine_reg, routine_next;
    logic [15:0]           index_reg, index_next;
    logic                  res_valid_reg, res_valid_next;

    // payload
    logic [DATA_WIDTH-1:0] t0_reg, t0_next;
    logic [DATA_WIDTH-1:0] t1_reg, t1_next;
    res_t                  res_reg, res_next;

    logic                  fire;
    logic                  is_step, jumped, ovf;
    logic                  push_en, pop_en, binop;
    logic [DATA_WIDTH-1:0] push_val, alu;
    logic [SIZE_W-1:0]     size_m2, size_m3;

    stk_wr_t               stk_wr;
    logic [DATA_WIDTH-1:0] stk_rd_data;
    var_wr_t               var_wr;
    logic [DATA_WIDTH-1:0] var_rd_data;

    assign cmd_stall = res_valid_reg && res_stall;
    assign fire      = cmd_valid && !cmd_stall;

    scp_stack_ram u_stack_ram (
        .clk     (clk),
        .wr      (stk_wr),
        .rd_addr (size_m3[STK_ADDR_W-1:0]),
        .rd_data (stk_rd_data)
    );

    scp_var_bank u_var_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (var_wr),
        .rd_idx  (cmd.var_index),
        .rd_data (var_rd_data)
    );

    always_comb
    begin
        unique case (cmd.mode)
            OP_ADD:  alu = t1_reg + t0_reg;
            OP_SUB:  alu = t1_reg - t0_reg;
            default: alu = t1_reg * t0_reg;
        endcase
    end

    // instruction decode
    always_comb
    begin
        is_step    = 1'b0;
        jumped     = 1'b0;
        push_en    = 1'b0;
        push_val   = '0;
        pop_en     = 1'b0;
        binop      = 1'b0;
        var_wr.en  = 1'b0;
        var_wr.idx = cmd.var_index;
        var_wr.data = '0;
        if (fire)
        begin
            unique case (cmd.mode) inside
                OP_PUSH:
                begin
                    is_step  = 1'b1;
                    push_en  = 1'b1;
                    push_val = cmd.constant;
                end
                OP_ADD, OP_SUB, OP_MUL:
                begin
                    is_step = 1'b1;
                    if (size_reg == '0)
                    begin
                        push_en = 1'b1;
                    end
                    else if (size_reg != SIZE_W'(1))
                    begin
                        pop_en = 1'b1;
                        binop  = 1'b1;
                    end
                end
                OP_READ:
                begin
                    // NUM_VARS spans every var_index code, so no range check
                    is_step  = 1'b1;
                    push_en  = 1'b1;
                    push_val = var_rd_data;
                end
                OP_WRITE:
                begin
                    is_step   = 1'b1;
                    var_wr.en = 1'b1;
                    if (size_reg != '0)
                    begin
                        var_wr.data = t0_reg;
                        pop_en      = 1'b1;
                    end
                end
                OP_JUMP:
                begin
                    is_step = 1'b1;
                    jumped  = 1'b1;
                end
                OP_JUMPZ:
                begin
                    is_step = 1'b1;
                    if ((size_reg == '0) || (t0_reg == '0))
                    begin
                        jumped = 1'b1;
                        pop_en = (size_reg != '0);
                    end
                end
                OP_ASSIGN:
                begin
                    var_wr.en   = 1'b1;
                    var_wr.data = cmd.constant;
                end
                default:
                begin
                end
            endcase
        end
    end

    // stack, position and counter update
    always_comb
    begin
        size_next    = size_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        time_next    = time_reg;
        routine_next = routine_reg;
        index_next   = index_reg;
        ovf          = 1'b0;
        size_m2      = size_reg - SIZE_W'(2);
        stk_wr.en    = 1'b0;
        stk_wr.addr  = size_m2[STK_ADDR_W-1:0];
        stk_wr.data  = t1_reg;

        if (push_en)
        begin
            if (size_reg == SIZE_FULL)
            begin
                ovf = 1'b1;
            end
            else
            begin
                stk_wr.en = (size_reg >= SIZE_W'(2));
                t1_next   = t0_reg;
                t0_next   = push_val;
                size_next = size_reg + SIZE_W'(1);
            end
        end
        else if (pop_en)
        begin
            t0_next   = binop ? alu : t1_reg;
            t1_next   = stk_rd_data;
            size_next = size_reg - SIZE_W'(1);
        end
        else if (fire && (size_reg == SIZE_W'(1)))
        begin
            // one-entry arithmetic
            if (cmd.mode == OP_SUB)
            begin
                t0_next = '0 - t0_reg;
            end
            else if (cmd.mode == OP_MUL)
            begin
                t0_next = '0;
            end
        end

        if (is_step)
        begin
            time_next = time_reg + 32'd1;
            if (jumped)
            begin
                // NUM_ROUTINES is a power of two: the modulo is a truncation
                routine_next = cmd.target_routine[ROUTINE_W-1:0];
                index_next   = '0;
            end
            else
            begin
                index_next = index_reg + 16'd1;
            end
        end

        // RAM read address tracks the third entry of the next stack
        size_m3 = size_next - SIZE_W'(3);
    end

    always_comb
    begin
        res_next               = res_reg;
        res_valid_next         = res_valid_reg && res_stall;
        if (fire)
        begin
            res_valid_next         = 1'b1;
            res_next.jump_taken    = jumped;
            res_next.routine       = 8'(routine_next);
            res_next.instr_index   = index_next;
            res_next.top_value     = (size_next == '0) ? '0 : t0_next;
            res_next.stack_count   = 7'(size_next);
            res_next.time_now      = time_next;
            res_next.overflow_flag = ovf;
            res_next.var_value     = var_wr.en ? var_wr.data : var_rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            time_reg      <= '0;
            routine_reg   <= '0;
            index_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            time_reg      <= time_next;
            routine_reg   <= routine_next;
            index_reg     <= index_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the stack calculator step unit.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_checker
    import scp_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_stall,
    input wire cmd_t cmd,
    input wire logic res_valid,
    input wire logic res_stall,
    input wire res_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("stalled result changed");

    // every accepted item yields a result in the next cycle
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> res_valid)
        else $error("accepted item produced no result");

    a_jump_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.mode == OP_JUMP)
        |=> res.jump_taken && (res.instr_index == 16'd0))
        else $error("jump did not reset position");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.overflow_flag |-> (res.stack_count == 7'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

endmodule

bind stack_calculator_step_unit scp_checker u_scp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire
